// ===== design/oale_pkg.sv =====
// Shared types, constants and helpers for the ordered array list engine.
`timescale 1ns / 1ps

package oale_pkg;

  localparam int CAPACITY    = 128;
  localparam int VALUE_WIDTH = 32;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int POS_W  = 8;
  localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_BITS    = 50;

  localparam int F_ST  = 0;
  localparam int F_RV  = 2;
  localparam int F_FP  = 34;
  localparam int F_LEN = 42;

  localparam int TREE_FAN = 8;

  function automatic int tree_levels(int n);
    int l;
    int s;
    l = 0;
    s = 1;
    while (s < n) begin
      s = s * TREE_FAN;
      l = l + 1;
    end
    return (l == 0) ? 1 : l;
  endfunction

  localparam int TREE_LVLS   = tree_levels(CAPACITY);
  localparam int TREE_LEAVES = TREE_FAN ** TREE_LVLS;
  localparam int WAIT_W      = $clog2(TREE_LVLS + 1);

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_FIND   = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_TREE,
    S_EXEC
  } state_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_CMP_POS,
    CMD_CMP_VAL,
    CMD_INS,
    CMD_DEL
  } cell_op_t;

  typedef struct packed {
    cell_op_t               kind;
    logic [IDX_W-1:0]       p;
    logic [VALUE_WIDTH-1:0] v;
    logic [CNT_W-1:0]       cnt;
  } cell_cmd_t;

  typedef struct packed {
    logic                   hit;
    logic [IDX_W-1:0]       idx;
    logic [VALUE_WIDTH-1:0] data;
  } node_t;

  function automatic logic [VALUE_WIDTH-1:0] to_store(logic signed [31:0] v);
    logic signed [63:0] e;
    e = 64'(v);
    return e[VALUE_WIDTH-1:0];
  endfunction

  function automatic logic [31:0] to_out(logic signed [VALUE_WIDTH-1:0] w);
    logic signed [63:0] e;
    e = 64'(w);
    return e[31:0];
  endfunction

endpackage

// ===== design/oale_cell.sv =====
// One list entry: holds a value, shifts to/from neighbors, flags a match.
`timescale 1ns / 1ps

module oale_cell
  import oale_pkg::*;
(
  input  logic                   clk,
  input  logic [IDX_W-1:0]       idx,
  input  cell_cmd_t              cmd,
  input  logic [VALUE_WIDTH-1:0] left_val,
  input  logic [VALUE_WIDTH-1:0] right_val,
  output logic [VALUE_WIDTH-1:0] val_q,
  output logic                   hit_q
);

  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic                   hit_r, hit_nxt;
  logic                   at_or_above;

  assign at_or_above = (idx >= cmd.p);

  always_comb begin
    val_nxt = val_r;
    hit_nxt = hit_r;
    unique case (cmd.kind)
      CMD_CMP_POS: hit_nxt = (idx == cmd.p);
      CMD_CMP_VAL: hit_nxt = (CNT_W'(idx) < cmd.cnt) && (val_r == cmd.v);
      CMD_INS: begin
        if (at_or_above) begin
          val_nxt = (idx == cmd.p) ? cmd.v : left_val;
        end
      end
      CMD_DEL: begin
        if (at_or_above) begin
          val_nxt = right_val;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    hit_r <= hit_nxt;
  end

  assign val_q = val_r;
  assign hit_q = hit_r;

endmodule

// ===== design/oale_tree.sv =====
// Registered first-hit reduction tree over all cells, fan-in of eight per level.
`timescale 1ns / 1ps

module oale_tree
  import oale_pkg::*;
(
  input  logic  clk,
  input  node_t leaf [CAPACITY],
  output node_t root
);

  node_t lvl [TREE_LVLS+1][TREE_LEAVES];

  genvar l, n;

  generate
    for (n = 0; n < TREE_LEAVES; n++) begin : g_leaf
      if (n < CAPACITY) begin : g_used
        assign lvl[0][n] = leaf[n];
      end else begin : g_pad
        assign lvl[0][n] = '0;
      end
    end

    for (l = 0; l < TREE_LVLS; l++) begin : g_lvl
      localparam int NODES = TREE_LEAVES / (TREE_FAN ** (l + 1));
      for (n = 0; n < TREE_LEAVES; n++) begin : g_node
        if (n < NODES) begin : g_used
          node_t node_r, node_nxt;
          always_comb begin
            node_nxt = '0;
            for (int k = TREE_FAN - 1; k >= 0; k--) begin
              if (lvl[l][n*TREE_FAN + k].hit) begin
                node_nxt = lvl[l][n*TREE_FAN + k];
              end
            end
          end
          always_ff @(posedge clk) begin
            node_r <= node_nxt;
          end
          assign lvl[l+1][n] = node_r;
        end else begin : g_pad
          assign lvl[l+1][n] = '0;
        end
      end
    end
  endgenerate

  assign root = lvl[TREE_LVLS][0];

endmodule

// ===== design/ordered_array_list_engine.sv =====
// Top level: bounded ordered list held in a chain of cells, stream in/out.
//
//  channel | dir | fields (tdata, lowest bit first)
//  in_     | in  | opcode[2:0], position[10:3], value[42:11]
//  out_    | out | status[1:0], read_value[33:2], found_position[41:34],
//          |     | list_length[49:42]
//
// Insert, clear and unused opcodes: accept, then execute.
// Find, read and delete: accept, the cell compare stage, a wait through each
// register level of the first-hit tree, then execute.
// Reset clears the list length and the output valid; entries and output data are not cleared.
// A stalled result holds in the output register; the next beat is taken
// meanwhile, and its execute step waits until the output register frees.
`timescale 1ns / 1ps

module ordered_array_list_engine
  import oale_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // opcode, position, value
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // status, read_value, found_position, list_length
);

  state_t                 state_r, state_nxt;
  logic [WAIT_W-1:0]      wait_r, wait_nxt;
  opcode_t                op_r, op_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  cell_cmd_t              cmd;
  node_t                  root;
  node_t                  leaf [CAPACITY];
  logic [VALUE_WIDTH-1:0] cell_val [CAPACITY];
  logic                   cell_hit [CAPACITY];

  logic [CMP_W-1:0]       pos_w, cnt_w;
  logic [IDX_W-1:0]       p_idx;
  logic                   ins_ok, rd_ok, full;
  opcode_t                in_op;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] left_v, right_v;
      if (i == 0) begin : g_first
        assign left_v = '0;
      end else begin : g_mid_l
        assign left_v = cell_val[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_v = '0;
      end else begin : g_mid_r
        assign right_v = cell_val[i+1];
      end
      oale_cell u_cell (
        .clk       (clk),
        .idx       (IDX_W'(i)),
        .cmd       (cmd),
        .left_val  (left_v),
        .right_val (right_v),
        .val_q     (cell_val[i]),
        .hit_q     (cell_hit[i])
      );
      assign leaf[i] = '{hit: cell_hit[i], idx: IDX_W'(i), data: cell_val[i]};
    end
  endgenerate

  oale_tree u_tree (
    .clk  (clk),
    .leaf (leaf),
    .root (root)
  );

  assign pos_w  = CMP_W'(pos_r);
  assign cnt_w  = CMP_W'(cnt_r);
  assign p_idx  = IDX_W'(pos_w - CMP_W'(1));
  assign ins_ok = (pos_r != '0) && (pos_w <= cnt_w + CMP_W'(1));
  assign rd_ok  = (pos_r != '0) && (pos_w <= cnt_w);
  assign full   = (cnt_r == CNT_W'(CAPACITY));
  assign in_op  = opcode_t'(in_tdata[2:0]);

  always_comb begin
    status_t     st;
    logic [31:0] rv;
    logic [7:0]  fp;
    state_nxt      = state_r;
    wait_nxt       = wait_r;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    cnt_nxt        = cnt_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    in_tready      = 1'b0;
    cmd            = '{kind: CMD_HOLD, p: p_idx, v: val_r, cnt: cnt_r};
    st             = ST_OK;
    rv             = '0;
    fp             = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt  = in_op;
          pos_nxt = in_tdata[10:3];
          val_nxt = to_store(in_tdata[42:11]);
          if (in_op == OP_FIND || in_op == OP_READ || in_op == OP_DELETE) begin
            state_nxt = S_CMP;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_CMP: begin
        cmd.kind  = (op_r == OP_FIND) ? CMD_CMP_VAL : CMD_CMP_POS;
        wait_nxt  = '0;
        state_nxt = S_TREE;
      end
      S_TREE: begin
        if (wait_r == WAIT_W'(TREE_LVLS - 1)) begin
          state_nxt = S_EXEC;
        end else begin
          wait_nxt = wait_r + WAIT_W'(1);
        end
      end
      S_EXEC: begin
        if (!out_tvalid_r || out_tready) begin
          unique case (op_r)
            OP_INSERT: begin
              if (!ins_ok) begin
                st = ST_BAD_POS;
              end else if (full) begin
                st = ST_FULL;
              end else begin
                cmd.kind = CMD_INS;
                cnt_nxt  = cnt_r + CNT_W'(1);
              end
            end
            OP_DELETE: begin
              if (!rd_ok) begin
                st = ST_BAD_POS;
              end else begin
                rv       = to_out(root.data);
                cmd.kind = CMD_DEL;
                cnt_nxt  = cnt_r - CNT_W'(1);
              end
            end
            OP_FIND: begin
              if (root.hit) begin
                fp = 8'(CMP_W'(root.idx) + CMP_W'(1));
              end else begin
                st = ST_NOT_FOUND;
              end
            end
            OP_READ: begin
              if (!rd_ok) begin
                st = ST_BAD_POS;
              end else begin
                rv = to_out(root.data);
              end
            end
            OP_CLEAR: cnt_nxt = '0;
            default: ;
          endcase
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {(OUT_TDATA_W - OUT_BITS)'(0), 8'(cnt_nxt), fp, rv, st};
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wait_r       <= '0;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wait_r       <= wait_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    pos_r       <= pos_nxt;
    val_r       <= val_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== design/oale_checker.sv =====
// Port-level checks for the ordered array list engine, bound to the top level.
`timescale 1ns / 1ps

module oale_checker
  import oale_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [1:0] st;
  logic [7:0] fp;
  logic [7:0] len;

  assign st  = out_tdata[F_ST +: 2];
  assign fp  = out_tdata[F_FP +: 8];
  assign len = out_tdata[F_LEN +: 8];

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat dropped or changed");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == ST_FULL |-> len == 8'(CAPACITY))
    else $error("list full reported with list not at capacity");

  a_miss_fpos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st == ST_BAD_POS || st == ST_NOT_FOUND) |-> fp == '0)
    else $error("found position set on a failed operation");

endmodule

bind ordered_array_list_engine oale_checker u_oale_checker (.*);

// ===== sim/tb.sv =====
// Testbench for the ordered array list engine: directed, full-list and random beats.
`timescale 1ns / 1ps

module tb;
  import oale_pkg::*;

  localparam int LIMIT = 600000;

  typedef struct packed {
    status_t     status;
    logic [31:0] read_value;
    logic [7:0]  found_position;
    logic [7:0]  list_length;
  } list_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic [VALUE_WIDTH-1:0] list_mem [CAPACITY];
  int                     list_len = 0;
  list_result_t           pending_results [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int cycles = 0;

  ordered_array_list_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // list behavior, applied when a beat is accepted
  function automatic list_result_t list_apply(logic [2:0] op, logic [7:0] pos,
                                              logic [31:0] value);
    list_result_t           r;
    logic signed [63:0]     ext;
    logic signed [63:0]     back;
    logic [VALUE_WIDTH-1:0] w;
    int                     p;
    r = '0;
    r.status = ST_OK;
    ext = {{32{value[31]}}, value};
    w = ext[VALUE_WIDTH-1:0];
    p = pos;
    case (op)
      OP_INSERT: begin
        if (p < 1 || p > list_len + 1) r.status = ST_BAD_POS;
        else if (list_len >= CAPACITY) r.status = ST_FULL;
        else begin
          for (int j = list_len; j >= p; j--) list_mem[j] = list_mem[j-1];
          list_mem[p-1] = w;
          list_len++;
        end
      end
      OP_DELETE, OP_READ: begin
        if (p < 1 || p > list_len) r.status = ST_BAD_POS;
        else begin
          back = $signed(list_mem[p-1]);
          r.read_value = back[31:0];
          if (op == OP_DELETE) begin
            for (int j = p; j < list_len; j++) list_mem[j-1] = list_mem[j];
            list_len--;
          end
        end
      end
      OP_FIND: begin
        r.status = ST_NOT_FOUND;
        for (int j = 0; j < list_len; j++) begin
          if (list_mem[j] == w) begin
            r.status = ST_OK;
            r.found_position = 8'(j + 1);
            break;
          end
        end
      end
      OP_CLEAR: list_len = 0;
      default: ;
    endcase
    r.list_length = 8'(list_len);
    return r;
  endfunction

  task automatic send_op(logic [2:0] op, logic [7:0] pos, logic [31:0] value);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'({value, pos, op});
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(list_apply(op, pos, value));
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = status_t'(out_tdata[F_ST +: 2]);
      got.read_value = out_tdata[F_RV +: 32];
      got.found_position = out_tdata[F_FP +: 8];
      got.list_length = out_tdata[F_LEN +: 8];
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat st=%0d rv=%h fp=%0d len=%0d", $time,
                 got.status, got.read_value, got.found_position, got.list_length);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status || got.read_value != want.read_value ||
            got.found_position != want.found_position ||
            got.list_length != want.list_length) begin
          errors++;
          $display("%0t: mismatch exp st=%0d rv=%h fp=%0d len=%0d act st=%0d rv=%h fp=%0d len=%0d",
                   $time, want.status, want.read_value, want.found_position,
                   want.list_length, got.status, got.read_value,
                   got.found_position, got.list_length);
        end
      end
    end
  end

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 32'($urandom_range(0, 7) - 4);
    if (r < 40) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'hffff_ffff;
        default: return 32'h0;
      endcase
    end
    return $urandom;
  endfunction

  task automatic test_directed;
    send_op(OP_READ, 8'd1, 32'd0);
    send_op(OP_DELETE, 8'd1, 32'd0);
    send_op(OP_FIND, 8'd0, 32'd0);
    send_op(OP_INSERT, 8'd0, 32'd9);
    send_op(OP_INSERT, 8'd2, 32'd9);
    send_op(OP_INSERT, 8'd1, 32'h7fff_ffff);
    send_op(OP_INSERT, 8'd2, 32'h8000_0000);
    send_op(OP_INSERT, 8'd1, 32'hffff_ffff);
    send_op(OP_INSERT, 8'd2, 32'h0);
    send_op(OP_INSERT, 8'd255, 32'd5);
    send_op(OP_FIND, 8'd255, 32'h8000_0000);
    send_op(OP_INSERT, 8'd5, 32'hffff_ffff);
    send_op(OP_FIND, 8'd0, 32'hffff_ffff);
    send_op(OP_READ, 8'd0, 32'd0);
    send_op(OP_READ, 8'd5, 32'hffff_ffff);
    send_op(OP_READ, 8'd6, 32'd0);
    send_op(OP_READ, 8'd255, 32'd0);
    send_op(OP_DELETE, 8'd0, 32'd0);
    send_op(OP_DELETE, 8'd1, 32'd0);
    send_op(OP_DELETE, 8'd4, 32'd0);
    send_op(OP_DELETE, 8'd4, 32'd0);
    send_op(3'd5, 8'd255, 32'hffff_ffff);
    send_op(3'd6, 8'd1, 32'h1234_5678);
    send_op(3'd7, 8'd128, 32'h8000_0001);
    send_op(OP_CLEAR, 8'd255, 32'hffff_ffff);
    send_op(OP_READ, 8'd1, 32'd0);
  endtask

  task automatic test_full_list;
    logic [31:0] v;
    send_op(OP_CLEAR, 8'd0, 32'd0);
    while (list_len < CAPACITY) begin
      v = pick_value();
      send_op(OP_INSERT, 8'($urandom_range(1, list_len + 1)), v);
    end
    send_op(OP_INSERT, 8'(CAPACITY + 1), 32'd1);
    send_op(OP_INSERT, 8'(CAPACITY), 32'd1);
    send_op(OP_INSERT, 8'd1, 32'd1);
    send_op(OP_INSERT, 8'd0, 32'd1);
    send_op(OP_FIND, 8'd0, v);
    send_op(OP_FIND, 8'd0, list_mem[CAPACITY-1]);
    send_op(OP_READ, 8'(CAPACITY), 32'd0);
    send_op(OP_READ, 8'(CAPACITY + 1), 32'd0);
    send_op(OP_DELETE, 8'(CAPACITY), 32'd0);
    send_op(OP_INSERT, 8'(CAPACITY), 32'h8000_0000);
    send_op(OP_DELETE, 8'd1, 32'd0);
  endtask

  task automatic test_random(int n);
    logic [2:0]  op;
    logic [7:0]  pos;
    logic [31:0] v;
    int          r;
    bit          grow;
    grow = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 149) grow = ~grow;
      r = $urandom_range(0, 99);
      v = pick_value();
      if (r < 6) begin
        op = 3'($urandom_range(0, 7));
        pos = 8'($urandom_range(0, 255));
        v = $urandom;
      end else if ($urandom_range(0, 299) == 0) begin
        op = OP_CLEAR;
        pos = 8'($urandom);
      end else begin
        r = $urandom_range(0, 99);
        if (r < (grow ? 45 : 15)) op = OP_INSERT;
        else if (r < (grow ? 60 : 55)) op = OP_DELETE;
        else if (r < (grow ? 80 : 78)) op = OP_FIND;
        else op = OP_READ;
        if (op == OP_INSERT) begin
          if ($urandom_range(0, 9) != 0) pos = 8'($urandom_range(1, list_len + 1));
          else pos = 8'($urandom_range(list_len + 1, 255));
        end else if (op == OP_FIND) begin
          pos = 8'($urandom);
          if (list_len > 0 && $urandom_range(0, 9) < 7)
            v = list_mem[$urandom_range(0, list_len - 1)];
        end else begin
          if (list_len > 0 && $urandom_range(0, 9) != 0)
            pos = 8'($urandom_range(1, list_len));
          else pos = 8'($urandom_range(0, 255));
        end
      end
      send_op(op, pos, v);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain();
    idle_pct = 30;
    stall_pct = 30;
    test_full_list();
    drain();
    idle_pct = 0;
    stall_pct = 0;
    test_random(400);
    drain();
    idle_pct = 71;
    test_random(400);
    drain();
    idle_pct = 0;
    stall_pct = 71;
    test_random(400);
    drain();
    idle_pct = 9;
    stall_pct = 9;
    test_random(400);
    drain();
    repeat (16) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/oale_pkg.sv
design/oale_cell.sv
design/oale_tree.sv
design/ordered_array_list_engine.sv
design/oale_checker.sv
sim/tb.sv
